// ----- rtl/core/crtm_pkg.sv -----
// Shared types, constants and helpers of the CIDR rule table matcher.
package crtm_pkg;

  // Table geometry
  localparam int unsigned RULE_SLOTS = 16;
  localparam int unsigned SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(RULE_SLOTS + 1);

  // Field widths of one word
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned LEN_W        = 8;
  localparam int unsigned CFG_W        = 5;

  // Family maxima
  localparam logic [LEN_W-1:0] V4_MAX_LEN = 8'd32;
  localparam logic [LEN_W-1:0] V6_MAX_LEN = 8'd128;

  // Bit positions of the IPv4 address inside the high word
  localparam int unsigned V4_LSB = 32;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic              slot_ok;
    logic              status;
    logic              v6;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // One stored rule
  typedef struct packed {
    logic              v6;
    logic [ADDR_W-1:0] pfx_hi;
    logic [ADDR_W-1:0] pfx_lo;
    logic [LEN_W-1:0]  len;
  } rule_t;

  // Mask of the first len bits of a 128-bit address, network order (MSB first)
  function automatic logic [2*ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [2*ADDR_W-1:0] ones;
    ones = '1;
    if (len >= V6_MAX_LEN) begin
      prefix_mask = ones;
    end else begin
      prefix_mask = ~(ones >> len);
    end
  endfunction

endpackage

// ----- rtl/core/crtm_front.sv -----
// Front end: unpacks an incoming word, checks the length and masks the prefix.
module crtm_front (
  input  logic                              op_i,
  input  logic [crtm_pkg::SLOT_FIELD_W-1:0] slot_i,
  input  logic                              is_v6_i,
  input  logic [crtm_pkg::ADDR_W-1:0]       addr_high_i,
  input  logic [crtm_pkg::ADDR_W-1:0]       addr_low_i,
  input  logic [crtm_pkg::LEN_W-1:0]        length_i,
  output crtm_pkg::cmd_t                    cmd_o
);

  logic [crtm_pkg::ADDR_W-1:0]   hi_fam;
  logic [crtm_pkg::ADDR_W-1:0]   lo_fam;
  logic [crtm_pkg::LEN_W-1:0]    max_len;
  logic [2*crtm_pkg::ADDR_W-1:0] mask;
  logic                          too_long;
  logic                          is_write;

  // IPv4 keeps only bits 63:32 of the high word
  always_comb begin
    if (is_v6_i) begin
      hi_fam = addr_high_i;
      lo_fam = addr_low_i;
    end else begin
      hi_fam = {addr_high_i[crtm_pkg::ADDR_W-1:crtm_pkg::V4_LSB],
                {crtm_pkg::V4_LSB{1'b0}}};
      lo_fam = '0;
    end
  end

  // Length check and host-bit mask for rule writes
  assign max_len  = is_v6_i ? crtm_pkg::V6_MAX_LEN : crtm_pkg::V4_MAX_LEN;
  assign is_write = (crtm_pkg::op_e'(op_i) == crtm_pkg::OP_WRITE);
  assign too_long = (length_i > max_len);
  assign mask     = crtm_pkg::prefix_mask(length_i);

  always_comb begin
    cmd_o.op      = crtm_pkg::op_e'(op_i);
    cmd_o.slot_ok = ({5'd0, slot_i} < 9'(crtm_pkg::RULE_SLOTS));
    cmd_o.status  = is_write && too_long;
    cmd_o.v6      = is_v6_i;
    cmd_o.slot    = crtm_pkg::SLOT_W'(slot_i);
    cmd_o.len     = length_i;
    if (is_write) begin
      cmd_o.addr_hi = hi_fam & mask[2*crtm_pkg::ADDR_W-1:crtm_pkg::ADDR_W];
      cmd_o.addr_lo = lo_fam & mask[crtm_pkg::ADDR_W-1:0];
    end else begin
      cmd_o.addr_hi = hi_fam;
      cmd_o.addr_lo = lo_fam;
    end
  end

endmodule

// ----- rtl/core/crtm_queue.sv -----
// Short command queue decoupling the front end from the table scan.
module crtm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  crtm_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output crtm_pkg::cmd_t head_o
);

  crtm_pkg::cmd_t                  entry_q [crtm_pkg::QUEUE_DEPTH];
  logic [crtm_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [crtm_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [crtm_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = (cnt_q == crtm_pkg::QCNT_W'(crtm_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and fill-level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == crtm_pkg::QPTR_W'(crtm_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == crtm_pkg::QPTR_W'(crtm_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/crtm_back.sv -----
// Back end: rule table, one-rule-per-cycle lookup scan and result register.
module crtm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [crtm_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       q_empty_i,
  input  crtm_pkg::cmd_t             q_head_i,
  output logic                       q_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic                       res_status_o,
  output logic                       res_covered_o,
  output logic                       res_exact_o
);

  crtm_pkg::back_state_e state_q, state_d;

  crtm_pkg::rule_t              table_mem [crtm_pkg::RULE_SLOTS];
  crtm_pkg::rule_t              rule_q;
  crtm_pkg::cmd_t               cmd_q;
  logic [crtm_pkg::CNT_W-1:0]   n_q;
  logic [crtm_pkg::CNT_W-1:0]   iss_q;
  logic                         chk_q;
  logic                         last_q;
  logic                         cov_q;
  logic                         ex_q;
  logic                         out_valid_q;
  logic                         out_status_q;
  logic                         out_cov_q;
  logic                         out_ex_q;

  logic                         out_free;
  logic                         is_lookup;
  logic                         issue;
  logic                         issue_last;
  logic                         start_lookup;
  logic                         take_write;
  logic                         load_done;
  logic                         mem_we;
  logic [crtm_pkg::LEN_W-1:0]   full_len;
  logic [crtm_pkg::LEN_W-1:0]   eff_len;
  logic [2*crtm_pkg::ADDR_W-1:0] rule_mask;
  logic                         hit_cov;
  logic                         hit_ex;

  assign out_free  = !out_valid_q || res_ready_i;
  assign is_lookup = (q_head_i.op == crtm_pkg::OP_LOOKUP);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crtm_pkg::BK_IDLE: begin
        if (!q_empty_i && out_free && is_lookup) begin
          state_d = (n_q == '0) ? crtm_pkg::BK_DONE : crtm_pkg::BK_SCAN;
        end
      end
      crtm_pkg::BK_SCAN: begin
        if (last_q) begin
          state_d = crtm_pkg::BK_DONE;
        end
      end
      crtm_pkg::BK_DONE: begin
        if (out_free) begin
          state_d = crtm_pkg::BK_IDLE;
        end
      end
      default: state_d = crtm_pkg::BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o      = 1'b0;
    start_lookup = 1'b0;
    take_write   = 1'b0;
    issue        = 1'b0;
    load_done    = 1'b0;
    unique case (state_q)
      crtm_pkg::BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o      = 1'b1;
          start_lookup = is_lookup;
          take_write   = !is_lookup;
        end
      end
      crtm_pkg::BK_SCAN: begin
        issue = (iss_q < n_q);
      end
      crtm_pkg::BK_DONE: begin
        load_done = out_free;
      end
      default: ;
    endcase
  end

  assign issue_last = issue && (iss_q == n_q - 1'b1);
  assign mem_we     = take_write && !q_head_i.status && q_head_i.slot_ok;

  // Per-rule compare against the lookup address
  assign full_len  = cmd_q.v6 ? crtm_pkg::V6_MAX_LEN : crtm_pkg::V4_MAX_LEN;
  assign eff_len   = (rule_q.len > full_len) ? full_len : rule_q.len;
  assign rule_mask = crtm_pkg::prefix_mask(eff_len);
  assign hit_cov   = (rule_q.v6 == cmd_q.v6) &&
                     (((({rule_q.pfx_hi, rule_q.pfx_lo}) ^
                        {cmd_q.addr_hi, cmd_q.addr_lo}) & rule_mask) == '0);
  assign hit_ex    = (rule_q.v6 == cmd_q.v6) && (rule_q.len == full_len) &&
                     (rule_q.pfx_hi == cmd_q.addr_hi) &&
                     (rule_q.pfx_lo == cmd_q.addr_lo);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crtm_pkg::BK_IDLE;
      n_q         <= '0;
      iss_q       <= '0;
      chk_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        n_q <= ({4'd0, cfg_wdata_i} > 9'(crtm_pkg::RULE_SLOTS)) ?
               crtm_pkg::CNT_W'(crtm_pkg::RULE_SLOTS) :
               crtm_pkg::CNT_W'(cfg_wdata_i);
      end
      if (start_lookup) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + 1'b1;
      end
      chk_q  <= issue;
      last_q <= issue_last;
      if (take_write || load_done) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers and accumulators
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_head_i;
    end
    if (start_lookup) begin
      cov_q <= 1'b0;
      ex_q  <= 1'b0;
    end else if (chk_q) begin
      cov_q <= cov_q | hit_cov;
      ex_q  <= ex_q | hit_ex;
    end
    if (take_write) begin
      out_status_q <= q_head_i.status;
      out_cov_q    <= 1'b0;
      out_ex_q     <= 1'b0;
    end else if (load_done) begin
      out_status_q <= 1'b0;
      out_cov_q    <= cov_q;
      out_ex_q     <= ex_q;
    end
  end

  // Rule table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[q_head_i.slot] <= '{v6:     q_head_i.v6,
                                    pfx_hi: q_head_i.addr_hi,
                                    pfx_lo: q_head_i.addr_lo,
                                    len:    q_head_i.len};
    end
    if (issue) begin
      rule_q <= table_mem[iss_q[crtm_pkg::SLOT_W-1:0]];
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_status_o  = out_status_q;
  assign res_covered_o = out_cov_q;
  assign res_exact_o   = out_ex_q;

endmodule

// ----- rtl/core/cidr_rule_table_matcher.sv -----
// A rule write yields its status word in the result register once the back end takes it from
// the queue; a lookup scans min(rules_in_use, 16) table entries, one table entry per cycle via
// the registered table port, and goes straight to its result with no rule in use. The queue
// accepts new words while the back end works, as long as it is not full.
// Reset (rst_ni low, asynchronous) clears rules_in_use, the queue and the valid flag of the result
// register; table contents are undefined until written.
module cidr_rule_table_matcher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: rules_in_use
  input  logic                       cfg_we_i,
  input  logic [crtm_pkg::CFG_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [143:0]               s_axis_tdata,  // slot, addr_high, addr_low, length
  input  logic [1:0]                 s_axis_tuser,  // op, is_v6
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata   // status, covered, exact
);

  crtm_pkg::cmd_t front_cmd;
  crtm_pkg::cmd_t q_head;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           res_status;
  logic           res_covered;
  logic           res_exact;

  // Classify incoming words
  crtm_front u_front (
    .op_i        (s_axis_tuser[0]),
    .slot_i      (s_axis_tdata[3:0]),
    .is_v6_i     (s_axis_tuser[1]),
    .addr_high_i (s_axis_tdata[67:4]),
    .addr_low_i  (s_axis_tdata[131:68]),
    .length_i    (s_axis_tdata[139:132]),
    .cmd_o       (front_cmd)
  );

  assign s_axis_tready = !q_full;

  crtm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  crtm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_status_o  (res_status),
    .res_covered_o (res_covered),
    .res_exact_o   (res_exact)
  );

  assign m_axis_tdata = {5'd0, res_exact, res_covered, res_status};

endmodule
